// ===== sv/spq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Word types, operation and status codes shared by the queue modules.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int VALUE_W       = 32;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_FIND   = 2'd2;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]                kind;
        logic signed [VALUE_W-1:0] operand_value;
    } t_in_word;

    typedef struct packed {
        logic [1:0]                status;
        logic [4:0]                entry_count;
        logic signed [VALUE_W-1:0] head_value;
        logic                      head_valid;
    } t_out_word;

    // operation broadcast to every cell
    typedef struct packed {
        logic                      ins;
        logic                      rem;
        logic signed [VALUE_W-1:0] operand;
    } t_cell_ctl;

endpackage
`default_nettype wire

// ===== sv/spq_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry; shifts right on insert at or ahead of it, left on remove at or
// ahead of it, and reports its compare results to its right neighbor and the unit.
// ----------------------------------------------------------------------------
module spq_cell (
    input  wire                            i_clk,
    input  wire  spq_pkg::t_cell_ctl       i_ctl,
    input  wire                            i_occ,
    input  wire                            i_found,
    input  wire                            i_left_keep,
    input  wire  signed [spq_pkg::VALUE_W-1:0] i_left_value,
    input  wire  signed [spq_pkg::VALUE_W-1:0] i_right_value,
    output logic                           o_keep,
    output logic                           o_match,
    output logic signed [spq_pkg::VALUE_W-1:0] o_value
);

    logic signed [spq_pkg::VALUE_W-1:0] r_value;
    logic signed [spq_pkg::VALUE_W-1:0] n_value;
    logic                               w_gt;

    assign w_gt    = i_occ && (r_value > i_ctl.operand);
    assign o_keep  = i_occ && (r_value >= i_ctl.operand);
    assign o_match = i_occ && (r_value == i_ctl.operand);
    assign o_value = r_value;

    always_comb begin
        n_value = r_value;
        if (i_ctl.ins && !o_keep) begin
            n_value = i_left_keep ? i_ctl.operand : i_left_value;
        end else if (i_ctl.rem && i_found && !w_gt) begin
            n_value = i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule
`default_nettype wire

// ===== sv/sorted_priority_queue_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue unit
// Bounded queue of signed 32-bit values kept in descending order.
// ----------------------------------------------------------------------------
// A command word (kind, operand_value) is taken when i_start is high and
// o_busy is low. o_busy stays low: a new word may follow in every cycle.
// Kinds: insert (after all entries >= value), remove first equal, find;
// the unused kind code acts as find.
// Each word yields one result word on o_out, marked by o_strobe for one
// cycle, in the cycle after acceptance (throughput 1 word/cycle).
// The result carries status, entry count, head value and a non-empty flag.
// The store is a row of DEPTH cells that all compare against the operand
// at once and shift toward their neighbors in the same cycle; the found
// flag is an OR over the cells' match outputs.
// Reset clears the entry count and the strobe; cell contents are not reset.
// The receiver cannot stall: a result is gone after its strobe cycle.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_start,
    input  wire spq_pkg::t_in_word  i_in,
    output logic                    o_busy,
    output logic                    o_strobe,
    output spq_pkg::t_out_word      o_out
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    spq_pkg::t_status   r_status;
    spq_pkg::t_status   n_status;
    logic               r_strobe;
    logic               w_full;
    logic               w_found;
    spq_pkg::t_cell_ctl w_ctl;

    logic                               w_occ   [DEPTH];
    logic                               w_keep  [DEPTH];
    logic [DEPTH-1:0]                   w_match;
    logic signed [spq_pkg::VALUE_W-1:0] w_value [DEPTH];
    logic [CW+4:0]                      w_count_ext;

    assign w_full  = (r_count == CW'(DEPTH));
    assign w_found = |w_match;

    assign w_ctl.ins     = i_start && (i_in.kind == spq_pkg::KIND_INSERT) && !w_full;
    assign w_ctl.rem     = i_start && (i_in.kind == spq_pkg::KIND_REMOVE);
    assign w_ctl.operand = i_in.operand_value;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic                               w_lk;
            logic signed [spq_pkg::VALUE_W-1:0] w_lv;
            logic signed [spq_pkg::VALUE_W-1:0] w_rv;

            assign w_occ[gi] = (CW'(gi) < r_count);

            if (gi == 0) begin : g_first
                assign w_lk = 1'b1;
                assign w_lv = i_in.operand_value;
            end else begin : g_mid
                assign w_lk = w_keep[gi-1];
                assign w_lv = w_value[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_last
                assign w_rv = w_value[gi];
            end else begin : g_inner
                assign w_rv = w_value[gi+1];
            end

            spq_cell u_cell (
                .i_clk         (i_clk),
                .i_ctl         (w_ctl),
                .i_occ         (w_occ[gi]),
                .i_found       (w_found),
                .i_left_keep   (w_lk),
                .i_left_value  (w_lv),
                .i_right_value (w_rv),
                .o_keep        (w_keep[gi]),
                .o_match       (w_match[gi]),
                .o_value       (w_value[gi])
            );
        end
    endgenerate

    always_comb begin
        n_count  = r_count;
        n_status = spq_pkg::ST_OK;
        case (i_in.kind)
            spq_pkg::KIND_INSERT: begin
                if (w_full) begin
                    n_status = spq_pkg::ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            spq_pkg::KIND_REMOVE: begin
                if (w_found) begin
                    n_count = r_count - CW'(1);
                end else begin
                    n_status = spq_pkg::ST_NOT_FOUND;
                end
            end
            default: begin
                if (!w_found) begin
                    n_status = spq_pkg::ST_NOT_FOUND;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_start;
            if (i_start) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_status <= n_status;
        end
    end

    assign w_count_ext = {5'd0, r_count};

    assign o_busy            = 1'b0;
    assign o_strobe          = r_strobe;
    assign o_out.status      = r_status;
    assign o_out.entry_count = w_count_ext[4:0];
    assign o_out.head_valid  = (r_count != '0);
    assign o_out.head_value  = (r_count != '0) ? w_value[0] : '0;

endmodule
`default_nettype wire
